>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> src/ilph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilph_pkg;

    localparam int MAX_LINES      = 256;
    localparam int NUM_DIRS       = 2;
    localparam int PRIORITY_WIDTH = 16;

    localparam int LINE_W     = 8;
    localparam int DIR_W      = 2;
    localparam int FUNC_W     = 2;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int HEAP_DEPTH = NUM_DIRS * MAX_LINES;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int SLOT_W     = 10;

    localparam logic [PRIORITY_WIDTH-1:0] PRIO_MAX = {PRIORITY_WIDTH{1'b1}};
    localparam logic [PRIORITY_WIDTH-1:0] BUMP     = PRIORITY_WIDTH'(4);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_DIR0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_DIR1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_DIR2 = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DIR_W-1:0]  direction;
        logic [LINE_W-1:0] line_index;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [DIR_W-1:0]  out_direction;
        logic [LINE_W-1:0] out_line;
        logic              was_queued;
        logic [SLOT_W-1:0] queue_length;
    } out_item_t;

    typedef struct packed {
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [DIR_W-1:0]          dir;
        logic [LINE_W-1:0]         line;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [CFG_W-1:0] lines_dir0;
        logic [CFG_W-1:0] lines_dir1;
        logic [CFG_W-1:0] lines_dir2;
    } lines_cfg_t;

    typedef struct packed {
        logic              heap_we;
        logic [ADDR_W-1:0] heap_waddr;
        entry_t            heap_wdata;
        logic [ADDR_W-1:0] heap_raddr0;
        logic [ADDR_W-1:0] heap_raddr1;
        logic              slot_we;
        logic [ADDR_W-1:0] slot_waddr;
        logic [SLOT_W-1:0] slot_wdata;
        logic [ADDR_W-1:0] slot_raddr;
    } mem_req_t;

    // Position-table address of a line
    function automatic logic [ADDR_W-1:0] key_of(input logic [DIR_W-1:0] dir,
                                                 input logic [LINE_W-1:0] line);
        logic [31:0] k;
        k = 32'(dir) * 32'(MAX_LINES) + 32'(line);
        return k[ADDR_W-1:0];
    endfunction

    // Distance of a line from the middle of its direction
    function automatic logic [PRIORITY_WIDTH-1:0] edge_prio(input logic [CFG_W-1:0] n,
                                                          input logic [LINE_W-1:0] line);
        logic [CFG_W-1:0] half;
        logic [CFG_W-1:0] ln;
        logic [CFG_W-1:0] d;
        half = n >> 1;
        ln   = CFG_W'(line);
        d    = (half >= ln) ? (half - ln) : (ln - half);
        return PRIORITY_WIDTH'(d);
    endfunction

endpackage

`default_nettype wire

>>> src/ilph_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ilph_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/ilph_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ilph_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire ilph_pkg::in_item_t       in_item,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output ilph_pkg::out_item_t           out_item,
    input  wire ilph_pkg::lines_cfg_t     cfg,
    output ilph_pkg::mem_req_t            mem_req,
    input  wire ilph_pkg::entry_t         heap_rdata0,
    input  wire ilph_pkg::entry_t         heap_rdata1,
    input  wire logic [ilph_pkg::SLOT_W-1:0] slot_rdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SLOT,
        S_ADD_HEAP,
        S_ADD_CHK,
        S_POP_LD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_PLACE,
        S_FINISH
    } state_t;

    state_t                             state_reg;
    logic [ilph_pkg::SLOT_W-1:0]        count_reg;
    logic [ilph_pkg::SLOT_W-1:0]        slot_reg;
    ilph_pkg::entry_t                   cur_reg;
    ilph_pkg::in_item_t                 item_reg;
    logic [ilph_pkg::ADDR_W-1:0]        key_reg;
    logic                               queued_reg;
    logic                               found_reg;
    logic [ilph_pkg::DIR_W-1:0]         pop_dir_reg;
    logic [ilph_pkg::LINE_W-1:0]        pop_line_reg;
    logic                               out_valid_reg;
    ilph_pkg::out_item_t                out_item_reg;

    logic                               accept;
    logic [ilph_pkg::SLOT_W:0]          left_pos;
    logic [ilph_pkg::SLOT_W:0]          right_pos;
    logic                               left_in;
    logic                               right_in;
    logic                               take_left;
    logic                               take_right;
    logic [ilph_pkg::PRIORITY_WIDTH-1:0] big_prio;
    logic                               up_swap;
    logic                               slot_hit;
    logic                               key_match;
    logic                               room;
    logic [ilph_pkg::CFG_W-1:0]         dir_lines;
    ilph_pkg::entry_t                   new_entry;
    ilph_pkg::entry_t                   bumped;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Decode the shared compare unit
    always_comb
    begin
        left_pos   = {slot_reg, 1'b0};
        right_pos  = left_pos + 1'b1;
        left_in    = (left_pos <= {1'b0, count_reg});
        right_in   = (right_pos <= {1'b0, count_reg});
        take_left  = left_in && (heap_rdata0.prio > cur_reg.prio);
        big_prio   = take_left ? heap_rdata0.prio : cur_reg.prio;
        take_right = right_in && (heap_rdata1.prio > big_prio);
        up_swap    = (heap_rdata0.prio < cur_reg.prio);
        slot_hit   = (slot_rdata != '0) && (slot_rdata <= count_reg);
        key_match  = (heap_rdata0.dir == item_reg.direction)
                     && (heap_rdata0.line == item_reg.line_index);
        room       = (count_reg < ilph_pkg::SLOT_W'(ilph_pkg::HEAP_DEPTH));
        case (item_reg.direction)
            2'd0:    dir_lines = cfg.lines_dir0;
            2'd1:    dir_lines = cfg.lines_dir1;
            default: dir_lines = cfg.lines_dir2;
        endcase
        new_entry.prio = ilph_pkg::edge_prio(dir_lines, item_reg.line_index);
        new_entry.dir  = item_reg.direction;
        new_entry.line = item_reg.line_index;
        bumped         = heap_rdata0;
        bumped.prio    = (heap_rdata0.prio > (ilph_pkg::PRIO_MAX - ilph_pkg::BUMP))
                         ? ilph_pkg::PRIO_MAX : heap_rdata0.prio + ilph_pkg::BUMP;
    end

    // Drive memory reads and writes from the sequencer state
    always_comb
    begin
        mem_req             = '0;
        mem_req.heap_wdata  = cur_reg;
        mem_req.slot_raddr  = key_reg;
        mem_req.heap_waddr  = ilph_pkg::ADDR_W'(slot_reg - 1'b1);
        mem_req.slot_wdata  = slot_reg;
        mem_req.slot_waddr  = ilph_pkg::key_of(cur_reg.dir, cur_reg.line);
        case (state_reg)
            S_IDLE:
            begin
                mem_req.heap_raddr0 = '0;
                mem_req.heap_raddr1 = ilph_pkg::ADDR_W'(count_reg - 1'b1);
            end
            S_ADD_HEAP:
            begin
                mem_req.heap_raddr0 = ilph_pkg::ADDR_W'(slot_rdata - 1'b1);
            end
            S_UP_RD:
            begin
                mem_req.heap_raddr0 = ilph_pkg::ADDR_W'((slot_reg >> 1) - 1'b1);
            end
            S_UP_CMP:
            begin
                if (up_swap)
                begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_wdata = heap_rdata0;
                    mem_req.slot_we    = 1'b1;
                    mem_req.slot_waddr = ilph_pkg::key_of(heap_rdata0.dir, heap_rdata0.line);
                end
            end
            S_DN_RD:
            begin
                mem_req.heap_raddr0 = ilph_pkg::ADDR_W'(left_pos - 1'b1);
                mem_req.heap_raddr1 = ilph_pkg::ADDR_W'(left_pos);
            end
            S_DN_CMP:
            begin
                if (take_right)
                begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_wdata = heap_rdata1;
                    mem_req.slot_we    = 1'b1;
                    mem_req.slot_waddr = ilph_pkg::key_of(heap_rdata1.dir, heap_rdata1.line);
                end
                else if (take_left)
                begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_wdata = heap_rdata0;
                    mem_req.slot_we    = 1'b1;
                    mem_req.slot_waddr = ilph_pkg::key_of(heap_rdata0.dir, heap_rdata0.line);
                end
            end
            S_PLACE:
            begin
                mem_req.heap_we = 1'b1;
                mem_req.slot_we = 1'b1;
            end
            default:
            begin
                mem_req.heap_raddr0 = '0;
            end
        endcase
    end

    // Sequence one item through the heap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            queued_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg     <= in_item;
                        key_reg      <= ilph_pkg::key_of(in_item.direction, in_item.line_index);
                        queued_reg   <= 1'b0;
                        found_reg    <= 1'b0;
                        pop_dir_reg  <= '0;
                        pop_line_reg <= '0;
                        case (in_item.func)
                            ilph_pkg::FUNC_ADD:
                            begin
                                if (32'(in_item.direction) < ilph_pkg::NUM_DIRS)
                                begin
                                    state_reg <= S_ADD_SLOT;
                                end
                                else
                                begin
                                    state_reg <= S_FINISH;
                                end
                            end
                            ilph_pkg::FUNC_POP:
                            begin
                                state_reg <= (count_reg == '0) ? S_FINISH : S_POP_LD;
                            end
                            ilph_pkg::FUNC_FLUSH:
                            begin
                                count_reg <= '0;
                                state_reg <= S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_ADD_SLOT:
                begin
                    state_reg <= S_ADD_HEAP;
                end
                S_ADD_HEAP, S_ADD_CHK:
                begin
                    if ((state_reg == S_ADD_HEAP) && slot_hit)
                    begin
                        slot_reg  <= slot_rdata;
                        state_reg <= S_ADD_CHK;
                    end
                    else if ((state_reg == S_ADD_CHK) && key_match)
                    begin
                        cur_reg    <= bumped;
                        queued_reg <= 1'b1;
                        state_reg  <= S_UP_RD;
                    end
                    else if (room)
                    begin
                        count_reg <= count_reg + 1'b1;
                        slot_reg  <= count_reg + 1'b1;
                        cur_reg   <= new_entry;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_POP_LD:
                begin
                    found_reg    <= 1'b1;
                    pop_dir_reg  <= heap_rdata0.dir;
                    pop_line_reg <= heap_rdata0.line;
                    count_reg    <= count_reg - 1'b1;
                    cur_reg      <= heap_rdata1;
                    slot_reg     <= ilph_pkg::SLOT_W'(1);
                    state_reg    <= (count_reg == ilph_pkg::SLOT_W'(1)) ? S_FINISH : S_DN_RD;
                end
                S_UP_RD:
                begin
                    state_reg <= (slot_reg == ilph_pkg::SLOT_W'(1)) ? S_PLACE : S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (up_swap)
                    begin
                        slot_reg  <= slot_reg >> 1;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_DN_RD:
                begin
                    state_reg <= left_in ? S_DN_CMP : S_PLACE;
                end
                S_DN_CMP:
                begin
                    if (take_right)
                    begin
                        slot_reg  <= right_pos[ilph_pkg::SLOT_W-1:0];
                        state_reg <= S_DN_RD;
                    end
                    else if (take_left)
                    begin
                        slot_reg  <= left_pos[ilph_pkg::SLOT_W-1:0];
                        state_reg <= S_DN_RD;
                    end
                    else
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_item_reg.found         <= found_reg;
                        out_item_reg.out_direction <= pop_dir_reg;
                        out_item_reg.out_line      <= pop_line_reg;
                        out_item_reg.was_queued    <= queued_reg;
                        out_item_reg.queue_length  <= count_reg;
                        state_reg                  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/indexed_line_priority_heap_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Handshake             Payload
// in        in_valid / in_stall   in_item   (func, direction, line_index)
// out       out_valid / out_stall out_item  (found .. queue_length)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time: add reads the position table, bumps a queued line or appends a
// new one, then climbs the heap level by level; pop takes the top, moves the last entry
// up and descends level by level. Flush, empty pop and ignored items go straight to the
// result, and the unit returns to idle before it takes the next item.
// The rate is set by one compare unit and the registered heap RAM reads per level.
// Reset clears the job count and sets each line count to 256; no clearing pass runs.
// in_stall is high while an item is in work; a held result stalls only completion.

module indexed_line_priority_heap_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire ilph_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output ilph_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ilph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ilph_pkg::CFG_W-1:0]      cfg_data
);

    ilph_pkg::lines_cfg_t             cfg_reg;
    ilph_pkg::mem_req_t               mem_req;
    ilph_pkg::entry_t                 heap_rdata0;
    ilph_pkg::entry_t                 heap_rdata1;
    logic [ilph_pkg::SLOT_W-1:0]      slot_rdata;

    assign cfg_ready = 1'b1;

    // Hold the line counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lines_dir0 <= ilph_pkg::CFG_W'(256);
            cfg_reg.lines_dir1 <= ilph_pkg::CFG_W'(256);
            cfg_reg.lines_dir2 <= ilph_pkg::CFG_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ilph_pkg::CFG_LINES_DIR0: cfg_reg.lines_dir0 <= cfg_data;
                ilph_pkg::CFG_LINES_DIR1: cfg_reg.lines_dir1 <= cfg_data;
                ilph_pkg::CFG_LINES_DIR2: cfg_reg.lines_dir2 <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    ilph_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg         (cfg_reg),
        .mem_req     (mem_req),
        .heap_rdata0 (heap_rdata0),
        .heap_rdata1 (heap_rdata1),
        .slot_rdata  (slot_rdata)
    );

    // Two heap copies written together give two read ports
    ilph_ram #(.WIDTH(ilph_pkg::ENTRY_W), .ADDR_W(ilph_pkg::ADDR_W)) u_heap_a (
        .clk   (clk),
        .we    (mem_req.heap_we),
        .waddr (mem_req.heap_waddr),
        .wdata (mem_req.heap_wdata),
        .raddr (mem_req.heap_raddr0),
        .rdata (heap_rdata0)
    );

    ilph_ram #(.WIDTH(ilph_pkg::ENTRY_W), .ADDR_W(ilph_pkg::ADDR_W)) u_heap_b (
        .clk   (clk),
        .we    (mem_req.heap_we),
        .waddr (mem_req.heap_waddr),
        .wdata (mem_req.heap_wdata),
        .raddr (mem_req.heap_raddr1),
        .rdata (heap_rdata1)
    );

    ilph_ram #(.WIDTH(ilph_pkg::SLOT_W), .ADDR_W(ilph_pkg::ADDR_W)) u_slot (
        .clk   (clk),
        .we    (mem_req.slot_we),
        .waddr (mem_req.slot_waddr),
        .wdata (mem_req.slot_wdata),
        .raddr (mem_req.slot_raddr),
        .rdata (slot_rdata)
    );

    `ASSERT_CLK(a_len_bound, !out_valid || (out_item.queue_length <= ilph_pkg::SLOT_W'(ilph_pkg::HEAP_DEPTH)), "queue length beyond heap depth")
    `ASSERT_CLK(a_pop_not_bump, !out_valid || !(out_item.found && out_item.was_queued), "pop and bump in one result")
    `ASSERT_CLK(a_empty_fields, !out_valid || out_item.found || ((out_item.out_direction == '0) && (out_item.out_line == '0)), "popped fields set without a job")
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not hold off input")

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [ilph_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    ilph_pkg::in_item_t             in_item;
    logic                           out_valid;
    logic                           out_stall;
    ilph_pkg::out_item_t            out_item;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ilph_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ilph_pkg::CFG_W-1:0]     cfg_data;

    indexed_line_priority_heap_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow heap: slots 1..jobs hold live entries
    logic [ilph_pkg::PRIORITY_WIDTH-1:0] sh_prio [1:ilph_pkg::HEAP_DEPTH];
    logic [ilph_pkg::DIR_W-1:0]          sh_dir  [1:ilph_pkg::HEAP_DEPTH];
    logic [ilph_pkg::LINE_W-1:0]         sh_line [1:ilph_pkg::HEAP_DEPTH];
    int                                  sh_slot [0:ilph_pkg::HEAP_DEPTH-1];
    int                                  sh_jobs;
    logic [ilph_pkg::CFG_W-1:0]          sh_lines [0:2];

    ilph_pkg::out_item_t expected_q [$];
    int        tx_pct;
    int        rx_pct;
    int        mismatches;
    int        cycles;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Randomly stall the result side
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_pct);
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        ilph_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_item);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.found !== out_item.found ||
                    want.out_direction !== out_item.out_direction ||
                    want.out_line !== out_item.out_line ||
                    want.was_queued !== out_item.was_queued ||
                    want.queue_length !== out_item.queue_length)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp f=%0d d=%0d l=%0d q=%0d n=%0d, ",
                                  "got f=%0d d=%0d l=%0d q=%0d n=%0d"},
                                 want.found, want.out_direction, want.out_line,
                                 want.was_queued, want.queue_length,
                                 out_item.found, out_item.out_direction, out_item.out_line,
                                 out_item.was_queued, out_item.queue_length);
                end
            end
        end
    end

    function automatic int line_key(input logic [ilph_pkg::DIR_W-1:0] d,
                                    input logic [ilph_pkg::LINE_W-1:0] l);
        return int'(d) * ilph_pkg::MAX_LINES + int'(l);
    endfunction

    function automatic void swap_entries(input int a, input int b);
        logic [ilph_pkg::PRIORITY_WIDTH-1:0] p;
        logic [ilph_pkg::DIR_W-1:0]          d;
        logic [ilph_pkg::LINE_W-1:0]         l;
        p = sh_prio[a]; d = sh_dir[a]; l = sh_line[a];
        sh_prio[a] = sh_prio[b]; sh_dir[a] = sh_dir[b]; sh_line[a] = sh_line[b];
        sh_prio[b] = p; sh_dir[b] = d; sh_line[b] = l;
        sh_slot[line_key(sh_dir[a], sh_line[a])] = a;
        sh_slot[line_key(sh_dir[b], sh_line[b])] = b;
    endfunction

    function automatic void climb(input int s);
        while (s > 1 && sh_prio[s / 2] < sh_prio[s])
        begin
            swap_entries(s, s / 2);
            s = s / 2;
        end
    endfunction

    function automatic void descend(input int s);
        int l;
        int r;
        int big;
        forever
        begin
            l = 2 * s;
            r = l + 1;
            big = s;
            if (l <= sh_jobs && sh_prio[l] > sh_prio[s])
                big = l;
            if (r <= sh_jobs && sh_prio[r] > sh_prio[big])
                big = r;
            if (big == s)
                return;
            swap_entries(s, big);
            s = big;
        end
    endfunction

    // Apply one operation to the shadow heap and return its result
    function automatic ilph_pkg::out_item_t heap_step(input ilph_pkg::in_item_t it);
        ilph_pkg::out_item_t r;
        int        k;
        int        s;
        int        half;
        int        pr;
        r = '0;
        if (it.func == ilph_pkg::FUNC_ADD)
        begin
            if (int'(it.direction) < ilph_pkg::NUM_DIRS)
            begin
                k = line_key(it.direction, it.line_index);
                s = sh_slot[k];
                if (s != 0 && s <= sh_jobs)
                begin
                    if (sh_prio[s] > ilph_pkg::PRIO_MAX - ilph_pkg::BUMP)
                        sh_prio[s] = ilph_pkg::PRIO_MAX;
                    else
                        sh_prio[s] = sh_prio[s] + ilph_pkg::BUMP;
                    climb(s);
                    r.was_queued = 1'b1;
                end
                else if (sh_jobs < ilph_pkg::HEAP_DEPTH)
                begin
                    half = int'(sh_lines[it.direction]) / 2;
                    pr = (half >= int'(it.line_index)) ? half - int'(it.line_index)
                                                       : int'(it.line_index) - half;
                    sh_jobs++;
                    sh_prio[sh_jobs] = pr[ilph_pkg::PRIORITY_WIDTH-1:0];
                    sh_dir[sh_jobs]  = it.direction;
                    sh_line[sh_jobs] = it.line_index;
                    sh_slot[k] = sh_jobs;
                    climb(sh_jobs);
                end
            end
        end
        else if (it.func == ilph_pkg::FUNC_POP)
        begin
            if (sh_jobs > 0)
            begin
                r.found = 1'b1;
                r.out_direction = sh_dir[1];
                r.out_line = sh_line[1];
                sh_slot[line_key(sh_dir[1], sh_line[1])] = 0;
                sh_jobs--;
                if (sh_jobs > 0)
                begin
                    sh_prio[1] = sh_prio[sh_jobs + 1];
                    sh_dir[1]  = sh_dir[sh_jobs + 1];
                    sh_line[1] = sh_line[sh_jobs + 1];
                    sh_slot[line_key(sh_dir[1], sh_line[1])] = 1;
                    descend(1);
                end
            end
        end
        else if (it.func == ilph_pkg::FUNC_FLUSH)
        begin
            for (int i = 0; i < ilph_pkg::HEAP_DEPTH; i++)
                sh_slot[i] = 0;
            sh_jobs = 0;
        end
        r.queue_length = sh_jobs[ilph_pkg::SLOT_W-1:0];
        return r;
    endfunction

    // Send one item, with random idle cycles ahead of it
    task automatic send_item(input logic [ilph_pkg::FUNC_W-1:0] f,
                             input logic [ilph_pkg::DIR_W-1:0] d,
                             input logic [ilph_pkg::LINE_W-1:0] l);
        ilph_pkg::in_item_t it;
        it.func = f;
        it.direction = d;
        it.line_index = l;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(heap_step(it));
    endtask

    // Hold off until every result is back and the block is quiet
    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ilph_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ilph_pkg::CFG_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sh_lines[idx] = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_lines(input int n0, input int n1, input int n2);
        write_reg(ilph_pkg::CFG_LINES_DIR0, n0[ilph_pkg::CFG_W-1:0]);
        write_reg(ilph_pkg::CFG_LINES_DIR1, n1[ilph_pkg::CFG_W-1:0]);
        write_reg(ilph_pkg::CFG_LINES_DIR2, n2[ilph_pkg::CFG_W-1:0]);
    endtask

    // Edges, bumps, ignored adds, empty pops and flush
    task automatic test_directed;
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_ADD, 0, 0);
        send_item(ilph_pkg::FUNC_ADD, 0, 255);
        send_item(ilph_pkg::FUNC_ADD, 0, 128);
        send_item(ilph_pkg::FUNC_ADD, 1, 0);
        send_item(ilph_pkg::FUNC_ADD, 1, 255);
        send_item(ilph_pkg::FUNC_ADD, 0, 128);
        send_item(ilph_pkg::FUNC_ADD, 0, 128);
        send_item(ilph_pkg::FUNC_ADD, 2, 5);
        send_item(ilph_pkg::FUNC_ADD, 3, 255);
        send_item(FUNC_NONE, 3, 255);
        send_item(ilph_pkg::FUNC_ADD, 1, 300 % 256);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 3, 255);
        send_item(ilph_pkg::FUNC_ADD, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_ADD, 1, 7);
        send_item(ilph_pkg::FUNC_FLUSH, 0, 0);
        send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_ADD, 1, 7);
        send_item(ilph_pkg::FUNC_FLUSH, 3, 255);
    endtask

    // Random mix of operations; sparse picks few lines so bumps are common
    task automatic test_random(input int count, input bit sparse);
        int r;
        logic [ilph_pkg::LINE_W-1:0] l;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            l = (sparse && $urandom_range(0, 3) != 0)
                ? ilph_pkg::LINE_W'($urandom_range(0, 11))
                : ilph_pkg::LINE_W'($urandom_range(0, 255));
            if (r < 58)
                send_item(ilph_pkg::FUNC_ADD, ilph_pkg::DIR_W'($urandom_range(0, 1)), l);
            else if (r < 88)
                send_item(ilph_pkg::FUNC_POP, ilph_pkg::DIR_W'($urandom_range(0, 3)), l);
            else if (r < 91)
                send_item(ilph_pkg::FUNC_FLUSH, ilph_pkg::DIR_W'($urandom_range(0, 3)), l);
            else if (r < 95)
                send_item(FUNC_NONE, ilph_pkg::DIR_W'($urandom_range(0, 3)), l);
            else
                send_item(ilph_pkg::FUNC_ADD, ilph_pkg::DIR_W'($urandom_range(2, 3)), l);
        end
    endtask

    // Load every line once in random order, bump some, then pop a while
    task automatic test_fill;
        int keys [ilph_pkg::HEAP_DEPTH];
        int j;
        int t;
        for (int i = 0; i < ilph_pkg::HEAP_DEPTH; i++)
            keys[i] = i;
        for (int i = ilph_pkg::HEAP_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = keys[i];
            keys[i] = keys[j];
            keys[j] = t;
        end
        for (int i = 0; i < ilph_pkg::HEAP_DEPTH; i++)
            send_item(ilph_pkg::FUNC_ADD,
                      ilph_pkg::DIR_W'(keys[i] / ilph_pkg::MAX_LINES),
                      ilph_pkg::LINE_W'(keys[i] % ilph_pkg::MAX_LINES));
        for (int i = 0; i < 30; i++)
            send_item(ilph_pkg::FUNC_ADD, ilph_pkg::DIR_W'($urandom_range(0, 1)),
                      ilph_pkg::LINE_W'($urandom_range(0, 255)));
        for (int i = 0; i < 80; i++)
            send_item(ilph_pkg::FUNC_POP, 0, 0);
        send_item(ilph_pkg::FUNC_FLUSH, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        tx_pct = 6;
        rx_pct = 51;
        sh_jobs = 0;
        for (int i = 0; i < ilph_pkg::HEAP_DEPTH; i++)
            sh_slot[i] = 0;
        for (int i = 0; i < 3; i++)
            sh_lines[i] = ilph_pkg::CFG_W'(256);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(300, 1'b1);
        set_lines(1, 1, 1);
        test_directed();
        test_random(200, 1'b0);

        tx_pct = 51;
        rx_pct = 6;
        set_lines(256, 1, 17);
        test_random(300, 1'b1);
        set_lines($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(1, 256));
        test_random(200, 1'b0);

        tx_pct = 0;
        rx_pct = 0;
        set_lines(3, 256, 256);
        test_fill();
        set_lines($urandom_range(1, 256), $urandom_range(1, 256), 1);
        test_random(220, 1'b1);

        drain();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/ilph_pkg.sv
src/ilph_ram.sv
src/ilph_ctrl.sv
src/indexed_line_priority_heap_unit.sv
test/tb_top.sv
